// File: rtl/number_literal_parser_core_assert.svh
`ifndef NUMBER_LITERAL_PARSER_CORE_ASSERT_SVH
`define NUMBER_LITERAL_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NLP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("number literal parser check failed");

// Implication checked in the cycle after the antecedent.
`define NLP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("number literal parser check failed");

`endif

// File: rtl/nlp_pkg.sv
package nlp_pkg;

  typedef enum logic [1:0] {
    PH_START,
    PH_SIGNED,
    PH_BODY,
    PH_SPECIAL
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_BIN = 2'd1;
  localparam logic [1:0] RADIX_OCT = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_REAL = 2'd1;
  localparam logic [1:0] KIND_INF  = 2'd2;
  localparam logic [1:0] KIND_NAN  = 2'd3;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;
  localparam logic [1:0] SIZE_NONE = 2'd3;

  localparam logic [63:0] NEG_BYTE_LIMIT  = 64'h80;
  localparam logic [63:0] NEG_HALF_LIMIT  = 64'h8000;
  localparam logic [63:0] POS_BYTE_LIMIT  = 64'hFF;
  localparam logic [63:0] POS_HALF_LIMIT  = 64'hFFFF;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_UP_I  = 8'h49;
  localparam logic [7:0] CH_UP_N  = 8'h4E;
  localparam logic [7:0] CH_UP_X  = 8'h58;

  // Clearing bit 5 maps a lower-case letter onto its upper-case code.
  localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;

  localparam logic [1:0] WORD_LENGTH = 2'd3;

  function automatic digit_t digit_of(input logic [7:0] c, input logic [1:0] radix);
    digit_t d;
    d = '0;
    case (radix)
      RADIX_BIN: begin
        if (c inside {8'h30, 8'h31}) begin
          d.ok    = 1'b1;
          d.value = 4'(c - CH_ZERO);
        end
      end
      RADIX_OCT: begin
        if (c inside {[8'h30:8'h37]}) begin
          d.ok    = 1'b1;
          d.value = 4'(c - CH_ZERO);
        end
      end
      default: begin
        if (c inside {[8'h30:8'h39]}) begin
          d.ok    = 1'b1;
          d.value = 4'(c - CH_ZERO);
        end else if (radix == RADIX_HEX && c inside {[8'h41:8'h46]}) begin
          d.ok    = 1'b1;
          d.value = 4'(c - 8'h37);
        end else if (radix == RADIX_HEX && c inside {[8'h61:8'h66]}) begin
          d.ok    = 1'b1;
          d.value = 4'(c - 8'h57);
        end
      end
    endcase
    return d;
  endfunction

  // Upper-case letter expected at a position of INF or NAN.
  function automatic logic [7:0] special_letter(input logic is_nan, input logic [1:0] idx);
    logic [7:0] letter;
    letter = CH_UP_N;
    case (idx)
      2'd0:    letter = is_nan ? CH_UP_N : CH_UP_I;
      2'd1:    letter = is_nan ? CH_UP_A : CH_UP_N;
      2'd2:    letter = is_nan ? CH_UP_N : CH_UP_F;
      default: letter = CH_UP_N;
    endcase
    return letter;
  endfunction

endpackage

// File: rtl/number_literal_parser_core.sv
// Channel | Handshake          | Payload
// input   | in_valid, in_stall  | character, last_char
// output  | out_valid, out_stall| error, negative, kind, radix, integer_value,
//         |                     | fraction_value, fraction_digits, size_class, overflow
//
// One character is taken per cycle unless in_stall is high; each waits in the input register.
// The integer accumulate (times base plus digit) and its wrap check are combinational.
// A result is loaded into the output register as its last character leaves the input register.
// The input stalls only while a last character waits behind an unaccepted result.
// Synchronous reset returns the parser to its start state and empties both registers.
module number_literal_parser_core #(
  parameter int VALUE_WIDTH         = 32,
  parameter int MAX_FRACTION_DIGITS = 9
) (
  clk,
  rst,
  in_valid,
  in_stall,
  character,
  last_char,
  out_valid,
  out_stall,
  error,
  negative,
  kind,
  radix,
  integer_value,
  fraction_value,
  fraction_digits,
  size_class,
  overflow
);

  function automatic int frac_bits(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return $clog2(p);
  endfunction

  localparam int FRAC_WIDTH  = frac_bits(MAX_FRACTION_DIGITS);
  localparam int COUNT_WIDTH = $clog2(MAX_FRACTION_DIGITS + 1);
  localparam int WIDE_WIDTH  = VALUE_WIDTH + 4;

  input  logic                   clk;
  input  logic                   rst;
  input  logic                   in_valid;
  output logic                   in_stall;
  input  logic [7:0]             character;
  input  logic                   last_char;
  output logic                   out_valid;
  input  logic                   out_stall;
  output logic                   error;
  output logic                   negative;
  output logic [1:0]             kind;
  output logic [1:0]             radix;
  output logic [VALUE_WIDTH-1:0] integer_value;
  output logic [FRAC_WIDTH-1:0]  fraction_value;
  output logic [COUNT_WIDTH-1:0] fraction_digits;
  output logic [1:0]             size_class;
  output logic                   overflow;

  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_last;
  logic       s1_advance;
  logic       load;

  nlp_pkg::phase_t        phase, phase_next, step_phase;
  logic                   sign_neg, sign_neg_next, step_sign_neg;
  logic [1:0]             radix_code, radix_code_next, step_radix_code;
  logic                   in_frac, in_frac_next, step_in_frac;
  logic [VALUE_WIDTH-1:0] int_acc, int_acc_next, step_int_acc;
  logic [FRAC_WIDTH-1:0]  frac_acc, frac_acc_next, step_frac_acc;
  logic [COUNT_WIDTH-1:0] frac_cnt, frac_cnt_next, step_frac_cnt;
  logic                   err_seen, err_seen_next, step_err_seen;
  logic                   ovf_seen, ovf_seen_next, step_ovf_seen;
  logic [1:0]             inf_match, inf_match_next, step_inf_match;
  logic [1:0]             nan_match, nan_match_next, step_nan_match;
  logic                   zero_lead, zero_lead_next, step_zero_lead;
  logic                   have_digits, have_digits_next, step_have_digits;

  logic [7:0]            folded;
  logic                  body_go;
  logic [1:0]            body_radix;
  nlp_pkg::digit_t       int_digit;
  nlp_pkg::digit_t       frac_digit;
  logic [WIDE_WIDTH-1:0] scaled;
  logic [WIDE_WIDTH-1:0] wide;

  logic                   res_ok;
  logic                   res_error;
  logic                   res_negative;
  logic [1:0]             res_kind;
  logic [1:0]             res_radix;
  logic [VALUE_WIDTH-1:0] res_integer;
  logic [FRAC_WIDTH-1:0]  res_fraction;
  logic [COUNT_WIDTH-1:0] res_digits;
  logic [1:0]             res_size;
  logic                   res_overflow;
  logic [63:0]            value64;

  assign s1_advance = s1_valid && (!s1_last || !out_valid || !out_stall);
  assign in_stall   = s1_valid && !s1_advance;
  assign load       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_char <= character;
      s1_last <= last_char;
    end
  end

  assign folded     = s1_char & nlp_pkg::CASE_FOLD_MASK;
  assign body_radix = zero_lead ? nlp_pkg::RADIX_OCT : radix_code;
  assign int_digit  = nlp_pkg::digit_of(s1_char, body_radix);
  assign frac_digit = nlp_pkg::digit_of(s1_char, nlp_pkg::RADIX_DEC);

  always_comb begin
    case (body_radix)
      nlp_pkg::RADIX_BIN: scaled = {3'b000, int_acc, 1'b0};
      nlp_pkg::RADIX_OCT: scaled = {1'b0, int_acc, 3'b000};
      nlp_pkg::RADIX_HEX: scaled = {int_acc, 4'b0000};
      default:            scaled = {1'b0, int_acc, 3'b000} + {3'b000, int_acc, 1'b0};
    endcase
  end

  assign wide = scaled + WIDE_WIDTH'(int_digit.value);

  always_comb begin
    step_phase       = phase;
    step_sign_neg    = sign_neg;
    step_radix_code  = radix_code;
    step_in_frac     = in_frac;
    step_int_acc     = int_acc;
    step_frac_acc    = frac_acc;
    step_frac_cnt    = frac_cnt;
    step_err_seen    = err_seen;
    step_ovf_seen    = ovf_seen;
    step_inf_match   = inf_match;
    step_nan_match   = nan_match;
    step_zero_lead   = zero_lead;
    step_have_digits = have_digits;
    body_go          = 1'b0;

    if (!err_seen) begin
      if (phase == nlp_pkg::PH_START && s1_char == nlp_pkg::CH_PLUS) begin
        step_phase = nlp_pkg::PH_SIGNED;
      end else if (phase == nlp_pkg::PH_START && s1_char == nlp_pkg::CH_MINUS) begin
        step_sign_neg = 1'b1;
        step_phase    = nlp_pkg::PH_SIGNED;
      end else if (phase == nlp_pkg::PH_START || phase == nlp_pkg::PH_SIGNED) begin
        if (folded == nlp_pkg::CH_UP_I) begin
          step_phase     = nlp_pkg::PH_SPECIAL;
          step_inf_match = 2'd1;
        end else if (folded == nlp_pkg::CH_UP_N) begin
          step_phase     = nlp_pkg::PH_SPECIAL;
          step_nan_match = 2'd1;
        end else begin
          step_phase = nlp_pkg::PH_BODY;
          if (s1_char == nlp_pkg::CH_ZERO) begin
            step_zero_lead   = 1'b1;
            step_have_digits = 1'b1;
          end else begin
            body_go = 1'b1;
          end
        end
      end else if (phase == nlp_pkg::PH_SPECIAL) begin
        if (inf_match != 2'd0) begin
          if (inf_match != nlp_pkg::WORD_LENGTH &&
              folded == nlp_pkg::special_letter(1'b0, inf_match)) begin
            step_inf_match = inf_match + 2'd1;
          end else begin
            step_err_seen = 1'b1;
          end
        end else begin
          if (nan_match != nlp_pkg::WORD_LENGTH &&
              folded == nlp_pkg::special_letter(1'b1, nan_match)) begin
            step_nan_match = nan_match + 2'd1;
          end else begin
            step_err_seen = 1'b1;
          end
        end
      end else begin
        body_go = 1'b1;
      end
    end

    if (body_go) begin
      step_zero_lead = 1'b0;
      if (zero_lead && folded == nlp_pkg::CH_UP_B) begin
        step_radix_code  = nlp_pkg::RADIX_BIN;
        step_have_digits = 1'b0;
      end else if (zero_lead && folded == nlp_pkg::CH_UP_X) begin
        step_radix_code  = nlp_pkg::RADIX_HEX;
        step_have_digits = 1'b0;
      end else begin
        step_radix_code = body_radix;
        if (in_frac) begin
          if (!frac_digit.ok) begin
            step_err_seen = 1'b1;
          end else if (frac_cnt < COUNT_WIDTH'(MAX_FRACTION_DIGITS)) begin
            step_frac_acc = FRAC_WIDTH'((frac_acc << 3) + (frac_acc << 1)) +
                            FRAC_WIDTH'(frac_digit.value);
            step_frac_cnt = frac_cnt + COUNT_WIDTH'(1);
          end else begin
            step_ovf_seen = 1'b1;
          end
        end else if (body_radix == nlp_pkg::RADIX_DEC && s1_char == nlp_pkg::CH_DOT) begin
          step_in_frac = 1'b1;
        end else if (!int_digit.ok) begin
          step_err_seen = 1'b1;
        end else begin
          if (wide[WIDE_WIDTH-1:VALUE_WIDTH] != 4'd0) begin
            step_ovf_seen = 1'b1;
          end
          step_int_acc     = wide[VALUE_WIDTH-1:0];
          step_have_digits = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (s1_last) begin
      phase_next       = nlp_pkg::PH_START;
      sign_neg_next    = 1'b0;
      radix_code_next  = nlp_pkg::RADIX_DEC;
      in_frac_next     = 1'b0;
      int_acc_next     = '0;
      frac_acc_next    = '0;
      frac_cnt_next    = '0;
      err_seen_next    = 1'b0;
      ovf_seen_next    = 1'b0;
      inf_match_next   = 2'd0;
      nan_match_next   = 2'd0;
      zero_lead_next   = 1'b0;
      have_digits_next = 1'b0;
    end else begin
      phase_next       = step_phase;
      sign_neg_next    = step_sign_neg;
      radix_code_next  = step_radix_code;
      in_frac_next     = step_in_frac;
      int_acc_next     = step_int_acc;
      frac_acc_next    = step_frac_acc;
      frac_cnt_next    = step_frac_cnt;
      err_seen_next    = step_err_seen;
      ovf_seen_next    = step_ovf_seen;
      inf_match_next   = step_inf_match;
      nan_match_next   = step_nan_match;
      zero_lead_next   = step_zero_lead;
      have_digits_next = step_have_digits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= nlp_pkg::PH_START;
      sign_neg    <= 1'b0;
      radix_code  <= nlp_pkg::RADIX_DEC;
      in_frac     <= 1'b0;
      int_acc     <= '0;
      frac_acc    <= '0;
      frac_cnt    <= '0;
      err_seen    <= 1'b0;
      ovf_seen    <= 1'b0;
      inf_match   <= 2'd0;
      nan_match   <= 2'd0;
      zero_lead   <= 1'b0;
      have_digits <= 1'b0;
    end else if (s1_advance) begin
      phase       <= phase_next;
      sign_neg    <= sign_neg_next;
      radix_code  <= radix_code_next;
      in_frac     <= in_frac_next;
      int_acc     <= int_acc_next;
      frac_acc    <= frac_acc_next;
      frac_cnt    <= frac_cnt_next;
      err_seen    <= err_seen_next;
      ovf_seen    <= ovf_seen_next;
      inf_match   <= inf_match_next;
      nan_match   <= nan_match_next;
      zero_lead   <= zero_lead_next;
      have_digits <= have_digits_next;
    end
  end

  assign value64 = 64'(step_int_acc);

  always_comb begin
    case (step_phase)
      nlp_pkg::PH_SPECIAL: res_ok = (step_inf_match == nlp_pkg::WORD_LENGTH) ||
                                    (step_nan_match == nlp_pkg::WORD_LENGTH);
      nlp_pkg::PH_BODY:    res_ok = step_in_frac ? (step_frac_cnt != '0) : step_have_digits;
      default:             res_ok = 1'b0;
    endcase
    if (step_err_seen) begin
      res_ok = 1'b0;
    end

    res_error    = 1'b0;
    res_negative = 1'b0;
    res_kind     = nlp_pkg::KIND_INT;
    res_radix    = nlp_pkg::RADIX_DEC;
    res_integer  = '0;
    res_fraction = '0;
    res_digits   = '0;
    res_size     = nlp_pkg::SIZE_BYTE;
    res_overflow = 1'b0;

    if (!res_ok) begin
      res_error = 1'b1;
    end else if (step_phase == nlp_pkg::PH_SPECIAL) begin
      res_negative = step_sign_neg;
      res_kind     = (step_inf_match != 2'd0) ? nlp_pkg::KIND_INF : nlp_pkg::KIND_NAN;
      res_size     = nlp_pkg::SIZE_NONE;
    end else begin
      res_negative = step_sign_neg;
      res_kind     = step_in_frac ? nlp_pkg::KIND_REAL : nlp_pkg::KIND_INT;
      res_radix    = step_radix_code;
      res_integer  = step_int_acc;
      res_fraction = step_frac_acc;
      res_digits   = step_frac_cnt;
      res_overflow = step_ovf_seen;
      if (step_in_frac || step_ovf_seen) begin
        res_size = nlp_pkg::SIZE_WORD;
      end else if (step_sign_neg) begin
        res_size = (value64 <= nlp_pkg::NEG_BYTE_LIMIT) ? nlp_pkg::SIZE_BYTE :
                   (value64 <= nlp_pkg::NEG_HALF_LIMIT) ? nlp_pkg::SIZE_HALF :
                                                          nlp_pkg::SIZE_WORD;
      end else begin
        res_size = (value64 <= nlp_pkg::POS_BYTE_LIMIT) ? nlp_pkg::SIZE_BYTE :
                   (value64 <= nlp_pkg::POS_HALF_LIMIT) ? nlp_pkg::SIZE_HALF :
                                                          nlp_pkg::SIZE_WORD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      error           <= res_error;
      negative        <= res_negative;
      kind            <= res_kind;
      radix           <= res_radix;
      integer_value   <= res_integer;
      fraction_value  <= res_fraction;
      fraction_digits <= res_digits;
      size_class      <= res_size;
      overflow        <= res_overflow;
    end
  end

`include "number_literal_parser_core_assert.svh"

  `NLP_ASSERT_NOW(a_error_clears_fields, out_valid && error,
    !negative && kind == nlp_pkg::KIND_INT && radix == nlp_pkg::RADIX_DEC &&
    integer_value == '0 && fraction_value == '0 && fraction_digits == '0 &&
    size_class == nlp_pkg::SIZE_BYTE && !overflow)
  `NLP_ASSERT_NEXT(a_last_restarts, s1_advance && s1_last,
    phase == nlp_pkg::PH_START && !err_seen && int_acc == '0 && frac_cnt == '0)
  `NLP_ASSERT_NOW(a_special_has_no_size, out_valid && !error &&
    (kind == nlp_pkg::KIND_INF || kind == nlp_pkg::KIND_NAN),
    size_class == nlp_pkg::SIZE_NONE && integer_value == '0)
  `NLP_ASSERT_NOW(a_digit_count_bound, out_valid,
    fraction_digits <= COUNT_WIDTH'(MAX_FRACTION_DIGITS))

endmodule

// File: bench/number_literal_parser_core_tb.sv
`timescale 1ns / 100ps

module number_literal_parser_core_tb;

  localparam int MAX_FRACTION = 9;
  localparam int CHARACTER_TARGET = 950;
  localparam int HOLD_CYCLES = 400;
  localparam logic [23:0] INF_TEXT = "INF";
  localparam logic [23:0] NAN_TEXT = "NAN";
  localparam logic [7:0] LOWER_CASE_BIT = ~nlp_pkg::CASE_FOLD_MASK;

  typedef struct packed {
    logic        error;
    logic        negative;
    logic [1:0]  kind;
    logic [1:0]  radix;
    logic [31:0] integer_value;
    logic [29:0] fraction_value;
    logic [3:0]  fraction_digits;
    logic [1:0]  size_class;
    logic        overflow;
  } parse_result_t;

  function automatic logic [7:0] word_letter(input logic is_nan, input logic [1:0] idx);
    return is_nan ? NAN_TEXT[8 * (2 - idx) +: 8] : INF_TEXT[8 * (2 - idx) +: 8];
  endfunction

  class literal_scoreboard;
    parse_result_t expected_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned malformed;
    int unsigned specials;
    int unsigned wrapped;
    nlp_pkg::phase_t ph;
    logic negative_seen, fraction_mode, bad_seen, wrap_seen, zero_first, digits_seen;
    logic [1:0] base_code;
    logic [31:0] int_acc;
    logic [29:0] frac_acc;
    logic [3:0] frac_count;
    logic [1:0] inf_count, nan_count;

    function void clear();
      ph = nlp_pkg::PH_START;
      negative_seen = 1'b0;
      fraction_mode = 1'b0;
      bad_seen = 1'b0;
      wrap_seen = 1'b0;
      zero_first = 1'b0;
      digits_seen = 1'b0;
      base_code = nlp_pkg::RADIX_DEC;
      int_acc = '0;
      frac_acc = '0;
      frac_count = '0;
      inf_count = '0;
      nan_count = '0;
    endfunction

    function int unsigned radix_base(input logic [1:0] r);
      case (r)
        nlp_pkg::RADIX_BIN: return 2;
        nlp_pkg::RADIX_OCT: return 8;
        nlp_pkg::RADIX_HEX: return 16;
        default:            return 10;
      endcase
    endfunction

    function bit digit_ok(input logic [7:0] c, input logic [1:0] r, output logic [3:0] v);
      logic [7:0] folded;
      folded = c & nlp_pkg::CASE_FOLD_MASK;
      v = c[3:0];
      if (c >= nlp_pkg::CH_ZERO && c <= nlp_pkg::CH_ZERO + 9) begin
        if (r == nlp_pkg::RADIX_BIN) return c <= nlp_pkg::CH_ZERO + 1;
        if (r == nlp_pkg::RADIX_OCT) return c <= nlp_pkg::CH_ZERO + 7;
        return 1'b1;
      end
      if (r == nlp_pkg::RADIX_HEX && folded >= nlp_pkg::CH_UP_A &&
          folded <= nlp_pkg::CH_UP_F) begin
        v = 4'(folded - nlp_pkg::CH_UP_A + 10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void take_body(input logic [7:0] c);
      logic [3:0] d;
      logic [63:0] wide;
      logic [7:0] folded;
      folded = c & nlp_pkg::CASE_FOLD_MASK;
      if (zero_first) begin
        zero_first = 1'b0;
        if (folded == nlp_pkg::CH_UP_B) begin
          base_code = nlp_pkg::RADIX_BIN;
          digits_seen = 1'b0;
          return;
        end
        if (folded == nlp_pkg::CH_UP_X) begin
          base_code = nlp_pkg::RADIX_HEX;
          digits_seen = 1'b0;
          return;
        end
        base_code = nlp_pkg::RADIX_OCT;
      end
      if (fraction_mode) begin
        if (!digit_ok(c, nlp_pkg::RADIX_DEC, d)) begin
          bad_seen = 1'b1;
          return;
        end
        if (frac_count < MAX_FRACTION) begin
          frac_acc = 30'(frac_acc * 10 + d);
          frac_count++;
        end else begin
          wrap_seen = 1'b1;
        end
        return;
      end
      if (base_code == nlp_pkg::RADIX_DEC && c == nlp_pkg::CH_DOT) begin
        fraction_mode = 1'b1;
        return;
      end
      if (!digit_ok(c, base_code, d)) begin
        bad_seen = 1'b1;
        return;
      end
      wide = 64'(int_acc) * 64'(radix_base(base_code)) + 64'(d);
      if (wide[63:32] != 32'd0) wrap_seen = 1'b1;
      int_acc = wide[31:0];
      digits_seen = 1'b1;
    endfunction

    function void take_first(input logic [7:0] c);
      logic [7:0] folded;
      folded = c & nlp_pkg::CASE_FOLD_MASK;
      if (folded == nlp_pkg::CH_UP_I) begin
        ph = nlp_pkg::PH_SPECIAL;
        inf_count = 2'd1;
        return;
      end
      if (folded == nlp_pkg::CH_UP_N) begin
        ph = nlp_pkg::PH_SPECIAL;
        nan_count = 2'd1;
        return;
      end
      ph = nlp_pkg::PH_BODY;
      if (c == nlp_pkg::CH_ZERO) begin
        zero_first = 1'b1;
        digits_seen = 1'b1;
        return;
      end
      take_body(c);
    endfunction

    function void take_special(input logic [7:0] c);
      logic [7:0] folded;
      folded = c & nlp_pkg::CASE_FOLD_MASK;
      if (inf_count != 0) begin
        if (inf_count < nlp_pkg::WORD_LENGTH && folded == word_letter(1'b0, inf_count))
          inf_count++;
        else bad_seen = 1'b1;
      end else begin
        if (nan_count < nlp_pkg::WORD_LENGTH && folded == word_letter(1'b1, nan_count))
          nan_count++;
        else bad_seen = 1'b1;
      end
    endfunction

    function void note_word(input logic [7:0] c, input logic last);
      parse_result_t r;
      logic ok;
      if (!bad_seen) begin
        if (ph == nlp_pkg::PH_START && c == nlp_pkg::CH_PLUS) begin
          ph = nlp_pkg::PH_SIGNED;
        end else if (ph == nlp_pkg::PH_START && c == nlp_pkg::CH_MINUS) begin
          negative_seen = 1'b1;
          ph = nlp_pkg::PH_SIGNED;
        end else if (ph == nlp_pkg::PH_START || ph == nlp_pkg::PH_SIGNED) begin
          take_first(c);
        end else if (ph == nlp_pkg::PH_SPECIAL) begin
          take_special(c);
        end else begin
          take_body(c);
        end
      end
      if (!last) return;
      r = '0;
      if (ph == nlp_pkg::PH_SPECIAL)
        ok = (inf_count == nlp_pkg::WORD_LENGTH) || (nan_count == nlp_pkg::WORD_LENGTH);
      else if (ph == nlp_pkg::PH_BODY) ok = fraction_mode ? (frac_count != 0) : digits_seen;
      else ok = 1'b0;
      if (bad_seen) ok = 1'b0;
      if (!ok) begin
        r.error = 1'b1;
        malformed++;
      end else if (ph == nlp_pkg::PH_SPECIAL) begin
        r.negative = negative_seen;
        r.kind = (inf_count != 0) ? nlp_pkg::KIND_INF : nlp_pkg::KIND_NAN;
        r.size_class = nlp_pkg::SIZE_NONE;
        specials++;
      end else begin
        r.negative = negative_seen;
        r.kind = fraction_mode ? nlp_pkg::KIND_REAL : nlp_pkg::KIND_INT;
        r.radix = base_code;
        r.integer_value = int_acc;
        r.fraction_value = frac_acc;
        r.fraction_digits = frac_count;
        r.overflow = wrap_seen;
        if (fraction_mode || wrap_seen) r.size_class = nlp_pkg::SIZE_WORD;
        else if (negative_seen)
          r.size_class = (int_acc <= nlp_pkg::NEG_BYTE_LIMIT) ? nlp_pkg::SIZE_BYTE :
                         (int_acc <= nlp_pkg::NEG_HALF_LIMIT) ? nlp_pkg::SIZE_HALF :
                                                                nlp_pkg::SIZE_WORD;
        else
          r.size_class = (int_acc <= nlp_pkg::POS_BYTE_LIMIT) ? nlp_pkg::SIZE_BYTE :
                         (int_acc <= nlp_pkg::POS_HALF_LIMIT) ? nlp_pkg::SIZE_HALF :
                                                                nlp_pkg::SIZE_WORD;
        if (wrap_seen) wrapped++;
      end
      expected_q.push_back(r);
      clear();
    endfunction

    function void compare(input string name, input logic [31:0] want_v,
                          input logic [31:0] got_v);
      if (want_v !== got_v) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want_v, got_v);
        mismatches++;
      end
    endfunction

    function void check_result(input parse_result_t got);
      parse_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result expected none, got error=%0b integer_value=%0h",
                 $time, got.error, got.integer_value);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      compare("error", 32'(want.error), 32'(got.error));
      compare("negative", 32'(want.negative), 32'(got.negative));
      compare("kind", 32'(want.kind), 32'(got.kind));
      compare("radix", 32'(want.radix), 32'(got.radix));
      compare("integer_value", want.integer_value, got.integer_value);
      compare("fraction_value", 32'(want.fraction_value), 32'(got.fraction_value));
      compare("fraction_digits", 32'(want.fraction_digits), 32'(got.fraction_digits));
      compare("size_class", 32'(want.size_class), 32'(got.size_class));
      compare("overflow", 32'(want.overflow), 32'(got.overflow));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  wire in_stall;
  logic [7:0] character = 8'd0;
  logic last_char = 1'b0;
  wire out_valid;
  logic out_stall = 1'b0;
  wire error;
  wire negative;
  wire [1:0] kind;
  wire [1:0] radix;
  wire [31:0] integer_value;
  wire [29:0] fraction_value;
  wire [3:0] fraction_digits;
  wire [1:0] size_class;
  wire overflow;

  literal_scoreboard book = new;
  logic [7:0] lit_q[$];
  int unsigned chars_sent = 0;
  int unsigned literals_sent = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;

  number_literal_parser_core uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .character(character),
    .last_char(last_char),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .error(error),
    .negative(negative),
    .kind(kind),
    .radix(radix),
    .integer_value(integer_value),
    .fraction_value(fraction_value),
    .fraction_digits(fraction_digits),
    .size_class(size_class),
    .overflow(overflow)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] any_case(input logic [7:0] up);
    return $urandom_range(1) ? (up | LOWER_CASE_BIT) : up;
  endfunction

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) lit_q.push_back(s[i]);
  endfunction

  function automatic void put_digits(input logic [1:0] r, input int n);
    int v;
    for (int i = 0; i < n; i++) begin
      case (r)
        nlp_pkg::RADIX_BIN: lit_q.push_back(nlp_pkg::CH_ZERO + 8'($urandom_range(1)));
        nlp_pkg::RADIX_OCT: lit_q.push_back(nlp_pkg::CH_ZERO + 8'($urandom_range(7)));
        nlp_pkg::RADIX_HEX: begin
          v = $urandom_range(15);
          if (v < 10) lit_q.push_back(nlp_pkg::CH_ZERO + 8'(v));
          else lit_q.push_back(any_case(nlp_pkg::CH_UP_A + 8'(v - 10)));
        end
        default: lit_q.push_back(nlp_pkg::CH_ZERO + 8'($urandom_range(9)));
      endcase
    end
  endfunction

  function automatic logic [32:0] near_limit();
    case ($urandom_range(13))
      0:       return 33'd0;
      1:       return 33'd1;
      2:       return 33'd127;
      3:       return 33'd128;
      4:       return 33'd129;
      5:       return 33'd255;
      6:       return 33'd256;
      7:       return 33'd32767;
      8:       return 33'd32768;
      9:       return 33'd32769;
      10:      return 33'd65535;
      11:      return 33'd65536;
      12:      return 33'hFFFF_FFFF;
      default: return 33'h1_0000_0000;
    endcase
  endfunction

  function automatic void build_valid();
    int n;
    logic is_nan;
    case ($urandom_range(2))
      1: lit_q.push_back(nlp_pkg::CH_PLUS);
      2: lit_q.push_back(nlp_pkg::CH_MINUS);
      default: ;
    endcase
    case ($urandom_range(9))
      0, 1: begin
        if ($urandom_range(3) == 0) begin
          put_str($sformatf("%0d", near_limit()));
        end else begin
          n = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
          lit_q.push_back(nlp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
          put_digits(nlp_pkg::RADIX_DEC, n - 1);
        end
      end
      2, 3: begin
        if ($urandom_range(2) != 0) begin
          lit_q.push_back(nlp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
          put_digits(nlp_pkg::RADIX_DEC, $urandom_range(2));
        end
        lit_q.push_back(nlp_pkg::CH_DOT);
        if ($urandom_range(7) == 0) put_str("999999999");
        else put_digits(nlp_pkg::RADIX_DEC, ($urandom_range(5) == 0) ?
                        $urandom_range(9, 12) : $urandom_range(1, 4));
      end
      4: begin
        lit_q.push_back(nlp_pkg::CH_ZERO);
        lit_q.push_back(any_case(nlp_pkg::CH_UP_X));
        put_digits(nlp_pkg::RADIX_HEX, ($urandom_range(7) == 0) ?
                   $urandom_range(9, 10) : $urandom_range(1, 8));
      end
      5: begin
        lit_q.push_back(nlp_pkg::CH_ZERO);
        lit_q.push_back(any_case(nlp_pkg::CH_UP_B));
        put_digits(nlp_pkg::RADIX_BIN, ($urandom_range(7) == 0) ?
                   $urandom_range(33, 34) : $urandom_range(1, 16));
      end
      6: begin
        lit_q.push_back(nlp_pkg::CH_ZERO);
        put_digits(nlp_pkg::RADIX_OCT, ($urandom_range(7) == 0) ?
                   $urandom_range(11, 12) : $urandom_range(6));
      end
      7: begin
        lit_q.push_back(nlp_pkg::CH_ZERO);
        lit_q.push_back(any_case(nlp_pkg::CH_UP_X));
        put_str($sformatf("%0h", near_limit()));
      end
      default: begin
        is_nan = 1'($urandom_range(1));
        for (int i = 0; i < 3; i++) lit_q.push_back(any_case(word_letter(is_nan, 2'(i))));
      end
    endcase
  endfunction

  function automatic void build_literal();
    int mode;
    mode = $urandom_range(99);
    if (mode < 88) build_valid();
    if (mode >= 65 && mode < 88) begin
      case ($urandom_range(3))
        0: lit_q[$urandom_range(lit_q.size() - 1)] = 8'($urandom_range(255));
        1: if (lit_q.size() > 1) void'(lit_q.pop_back());
        2: case ($urandom_range(4))
             0: lit_q.push_back(nlp_pkg::CH_DOT);
             1: lit_q.push_back(nlp_pkg::CH_PLUS);
             2: lit_q.push_back(nlp_pkg::CH_MINUS);
             3: lit_q.push_back(any_case(nlp_pkg::CH_UP_X));
             default: lit_q.push_back(8'($urandom_range(255)));
           endcase
        default: lit_q.push_back(nlp_pkg::CH_ZERO + 8'($urandom_range(9)));
      endcase
    end else if (mode >= 88) begin
      repeat ($urandom_range(1, 6)) lit_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic send_word(input logic [7:0] c, input logic l);
    while (!quiet && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    character <= c;
    last_char <= l;
    do @(posedge clk); while (in_stall);
    book.note_word(c, l);
    chars_sent++;
  endtask

  task automatic send_literal();
    foreach (lit_q[i]) send_word(lit_q[i], i == lit_q.size() - 1);
    lit_q.delete();
    literals_sent++;
  endtask

  initial begin : receive
    int hold_left;
    bit hold_done;
    parse_result_t got;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) begin
        got = {error, negative, kind, radix, integer_value, fraction_value,
               fraction_digits, size_class, overflow};
        book.check_result(got);
      end
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 14);
      end
    end
  end

  initial begin
    book.clear();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    put_str("0");
    send_literal();
    put_str("-0x");
    send_literal();
    put_str("08");
    send_literal();
    put_str("07");
    send_literal();
    put_str(".5");
    send_literal();
    put_str("-nAn");
    send_literal();
    put_str("+InF");
    send_literal();
    put_str("1.");
    send_literal();
    put_str("+");
    send_literal();
    lit_q.push_back(8'hFF);
    lit_q.push_back(8'h00);
    send_literal();

    while (chars_sent < CHARACTER_TARGET) begin
      if (literals_sent == 30) hold_go = 1'b1;
      quiet = (literals_sent >= 60 && literals_sent < 100);
      build_literal();
      send_literal();
    end
    in_valid <= 1'b0;

    while (book.expected_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);

    $display("Sent %0d literals in %0d characters; %0d results checked.",
             literals_sent, chars_sent, book.checked);
    $display("Among them %0d malformed, %0d INF or NAN, %0d with integer wrap or dropped digits.",
             book.malformed, book.specials, book.wrapped);
    if (book.mismatches == 0) begin
      $display("number_literal_parser_core_tb: PASS");
    end else begin
      $display("number_literal_parser_core_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("number_literal_parser_core_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/nlp_pkg.sv
rtl/number_literal_parser_core.sv
bench/number_literal_parser_core_tb.sv
